// ===== rtl/lqg_pkg.sv =====
`default_nettype none
package lqg_pkg;

  localparam int NumStates = 3;

  typedef enum logic [1:0] {
    REG_EXCITE = 2'd0,
    REG_SCALE  = 2'd1,
    REG_COUNTS = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_idx_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_ERR_MUL,    // prod = count * counts_scale
    DP_ERR_DONE,   // err = sat(prod - ref)
    DP_ROW_L,      // acc = L[row] * err
    DP_ROW_K,      // acc += Kreg[row][col] * x[col]
    DP_ROW_END,    // next[row] = sat(round(acc))
    DP_COMMIT,     // x = next, acc = 0
    DP_DRV_K,      // acc += K[col] * x[col]
    DP_DRV_END,    // drive = sat(round(-acc))
    DP_ZERO_DRV,
    DP_MAG,        // mag = |drive| * drive_scale
    DP_COMMUTE,    // update duties from hall
    DP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] row;
    logic [1:0] col;
    logic       use_cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic below_limit;
  } dp_stat_t;

  // Coefficients for a given fraction width, rounded half away from zero.
  function automatic logic signed [31:0] to_fixed(input longint dec, input int frac);
    longint mag;
    longint q;
    begin
      mag = (dec < 0) ? -dec : dec;
      q = (mag * (longint'(1) <<< frac) + 64'sd50000000) / 64'sd100000000;
      to_fixed = (dec < 0) ? 32'(-q) : 32'(q);
    end
  endfunction

  function automatic longint kreg_dec(input logic [1:0] r, input logic [1:0] c);
    logic [3:0] rc;
    begin
      rc = {r, c};
      case (rc)
        4'h0: kreg_dec = 76390000;
        4'h1: kreg_dec = -35800000;
        4'h2: kreg_dec = -52430000;
        4'h4: kreg_dec = 27520000;
        4'h5: kreg_dec = -14710000;
        4'h6: kreg_dec = -55000000;
        4'h8: kreg_dec = -25920000;
        4'h9: kreg_dec = 43650000;
        4'hA: kreg_dec = 65460000;
        default: kreg_dec = 0;
      endcase
    end
  endfunction

  function automatic longint lgain_dec(input logic [1:0] r);
    begin
      case (r)
        2'd0: lgain_dec = 28490;
        2'd1: lgain_dec = -8373;
        2'd2: lgain_dec = -121700;
        default: lgain_dec = 0;
      endcase
    end
  endfunction

  function automatic longint kgain_dec(input logic [1:0] r);
    begin
      case (r)
        2'd0: kgain_dec = -41370000;
        2'd1: kgain_dec = -68050000;
        2'd2: kgain_dec = 74400000;
        default: kgain_dec = 0;
      endcase
    end
  endfunction

  function automatic logic [1:0] phase_high(input logic [2:0] h);
    begin
      case (h)
        3'd1: phase_high = 2'd2;
        3'd2: phase_high = 2'd1;
        3'd3: phase_high = 2'd2;
        3'd6: phase_high = 2'd1;
        default: phase_high = 2'd0;
      endcase
    end
  endfunction

  function automatic logic [1:0] phase_low(input logic [2:0] h);
    begin
      case (h)
        3'd1: phase_low = 2'd1;
        3'd4: phase_low = 2'd2;
        3'd5: phase_low = 2'd1;
        3'd6: phase_low = 2'd2;
        default: phase_low = 2'd0;
      endcase
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lqg_ctrl.sv =====
`default_nettype none
module lqg_ctrl
  import lqg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     in_operation,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR_MUL, S_ERR_DONE, S_ROW_L, S_ROW_K, S_ROW_END, S_COMMIT,
    S_DRV_K, S_DRV_END, S_ZERO, S_MAG, S_COMMUTE, S_REPORT, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;
  logic       hall_op_r, hall_op_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    hall_op_nxt   = hall_op_r;
    out_valid_nxt = out_valid_r;
    cmd           = '{op: DP_NOP, row: row_r, col: col_r, use_cnt: 1'b0};
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          hall_op_nxt = in_operation;
          row_nxt     = 2'd0;
          col_nxt     = 2'd0;
          if (in_operation) state_nxt = S_MAG;
          else if (stat.below_limit) state_nxt = S_ERR_MUL;
          else state_nxt = S_ZERO;
        end
      end
      S_ERR_MUL: begin
        cmd.op = DP_ERR_MUL;
        state_nxt = S_ERR_DONE;
      end
      S_ERR_DONE: begin
        cmd.op = DP_ERR_DONE;
        state_nxt = S_ROW_L;
      end
      S_ROW_L: begin
        cmd.op = DP_ROW_L;
        col_nxt = 2'd0;
        state_nxt = S_ROW_K;
      end
      S_ROW_K: begin
        cmd.op = DP_ROW_K;
        if (col_r == 2'(NumStates - 1)) state_nxt = S_ROW_END;
        else col_nxt = col_r + 2'd1;
      end
      S_ROW_END: begin
        cmd.op = DP_ROW_END;
        if (row_r == 2'(NumStates - 1)) state_nxt = S_COMMIT;
        else begin
          row_nxt = row_r + 2'd1;
          state_nxt = S_ROW_L;
        end
      end
      S_COMMIT: begin
        cmd.op = DP_COMMIT;
        col_nxt = 2'd0;
        state_nxt = S_DRV_K;
      end
      S_DRV_K: begin
        cmd.op = DP_DRV_K;
        if (col_r == 2'(NumStates - 1)) state_nxt = S_DRV_END;
        else col_nxt = col_r + 2'd1;
      end
      S_DRV_END: begin
        cmd.op = DP_DRV_END;
        state_nxt = S_MAG;
      end
      S_ZERO: begin
        cmd.op = DP_ZERO_DRV;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.op = DP_MAG;
        state_nxt = (hall_op_r || row_r == 2'(NumStates - 1)) ? S_COMMUTE : S_REPORT;
      end
      S_COMMUTE: begin
        cmd.op = DP_COMMUTE;
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op = DP_REPORT;
          cmd.use_cnt = !hall_op_r && row_r == 2'(NumStates - 1);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      hall_op_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      hall_op_r   <= hall_op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lqg_dp.sv =====
`default_nettype none
module lqg_dp
  import lqg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic               in_take,
  input  wire logic signed [15:0] in_count_delta,
  input  wire logic               in_excite_bit,
  input  wire logic [2:0]         in_hall_bits,
  input  wire logic [15:0]        excite_speed,
  input  wire logic [11:0]        drive_scale,
  input  wire logic [31:0]        counts_scale,
  input  wire logic [21:0]        run_limit,
  output logic [11:0]             out_duty_a_high,
  output logic [11:0]             out_duty_a_low,
  output logic [11:0]             out_duty_b_high,
  output logic [11:0]             out_duty_b_low,
  output logic [11:0]             out_duty_c_high,
  output logic [11:0]             out_duty_c_low,
  output logic [2:0]              out_hall_indicator,
  output logic signed [15:0]      out_drive_report,
  output logic [15:0]             out_reference_report,
  output logic signed [15:0]      out_count_report
);

  localparam logic signed [63:0] SMax = 64'sh7FFFFFFF;
  localparam logic signed [63:0] SMin = -64'sh80000000;
  localparam logic signed [63:0] RoundHalf = 64'sd1 <<< (FRAC_BITS - 1);

  // coefficient tables, fixed at elaboration
  localparam logic [NumStates-1:0][31:0] LgainQ = {
    to_fixed(lgain_dec(2'd2), FRAC_BITS),
    to_fixed(lgain_dec(2'd1), FRAC_BITS),
    to_fixed(lgain_dec(2'd0), FRAC_BITS)
  };
  localparam logic [NumStates-1:0][31:0] KgainQ = {
    to_fixed(kgain_dec(2'd2), FRAC_BITS),
    to_fixed(kgain_dec(2'd1), FRAC_BITS),
    to_fixed(kgain_dec(2'd0), FRAC_BITS)
  };
  localparam logic [NumStates-1:0][NumStates-1:0][31:0] KregQ = {
    {to_fixed(kreg_dec(2'd2, 2'd2), FRAC_BITS),
     to_fixed(kreg_dec(2'd2, 2'd1), FRAC_BITS),
     to_fixed(kreg_dec(2'd2, 2'd0), FRAC_BITS)},
    {to_fixed(kreg_dec(2'd1, 2'd2), FRAC_BITS),
     to_fixed(kreg_dec(2'd1, 2'd1), FRAC_BITS),
     to_fixed(kreg_dec(2'd1, 2'd0), FRAC_BITS)},
    {to_fixed(kreg_dec(2'd0, 2'd2), FRAC_BITS),
     to_fixed(kreg_dec(2'd0, 2'd1), FRAC_BITS),
     to_fixed(kreg_dec(2'd0, 2'd0), FRAC_BITS)}
  };

  logic signed [31:0] x_r [NumStates];
  logic signed [31:0] nx_r [NumStates];
  logic signed [31:0] drive_r, err_r;
  logic signed [63:0] acc_r, prod_r;
  logic [11:0]        duty_r [6];
  logic [2:0]         ind_r, hall_r;
  logic [21:0]        tick_r;
  logic [15:0]        ref_r;
  logic signed [15:0] cnt_r;
  logic               exc_r;
  logic [43:0]        mag_r;

  logic signed [31:0] coef;
  logic signed [31:0] opnd;
  logic signed [63:0] mul;
  logic signed [63:0] shifted, e64, ref64;
  logic signed [63:0] rnd_in;
  logic [11:0]        torque;
  logic [1:0]         hi, lo;
  logic [31:0]        dmag;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    begin
      if (v > SMax) sat32 = 32'sh7FFFFFFF;
      else if (v < SMin) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  assign stat.below_limit = (tick_r < run_limit);

  always_comb begin
    coef = '0;
    opnd = '0;
    case (cmd.op)
      DP_ROW_L: begin
        coef = $signed(LgainQ[cmd.row]);
        opnd = err_r;
      end
      DP_ROW_K: begin
        coef = $signed(KregQ[cmd.row][cmd.col]);
        opnd = x_r[cmd.col];
      end
      DP_DRV_K: begin
        coef = $signed(KgainQ[cmd.col]);
        opnd = x_r[cmd.col];
      end
      default: ;
    endcase
    mul = 64'(coef) * 64'(opnd);
  end

  // round half up then arithmetic shift
  always_comb begin
    rnd_in  = (cmd.op == DP_DRV_END) ? -acc_r : acc_r;
    shifted = (rnd_in + RoundHalf) >>> FRAC_BITS;
    ref64   = $signed({16'd0, ref_r, 32'd0}) >>> 16;
    e64     = prod_r - ref64;
    if (FRAC_BITS >= 16) e64 = e64 <<< (FRAC_BITS - 16);
    else e64 = (e64 + (64'sd1 <<< (15 - FRAC_BITS + ((FRAC_BITS >= 16) ? 0 : 0))))
               >>> (16 - FRAC_BITS);
  end

  always_comb begin
    torque = (mag_r[43:FRAC_BITS] > 44'(drive_scale)) ? drive_scale
             : 12'(mag_r >> FRAC_BITS);
    hi = phase_high(hall_r);
    lo = phase_low(hall_r);
    if (drive_r < 0) begin
      hi = phase_low(hall_r);
      lo = phase_high(hall_r);
    end
    dmag = drive_r[31] ? 32'(-drive_r) : 32'(drive_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumStates; i++) x_r[i] <= '0;
      for (int i = 0; i < 6; i++) duty_r[i] <= '0;
      drive_r <= '0;
      ind_r   <= '0;
      tick_r  <= '0;
      ref_r   <= '0;
    end else begin
      if (in_take) begin
        cnt_r  <= in_count_delta;
        exc_r  <= in_excite_bit;
        hall_r <= in_hall_bits;
      end
      case (cmd.op)
        DP_ERR_MUL: begin
          prod_r <= 64'(cnt_r) * $signed({32'd0, counts_scale});
          ref_r  <= exc_r ? excite_speed : 16'd0;
          tick_r <= tick_r + 22'd1;
        end
        DP_ERR_DONE: err_r <= sat32(e64);
        DP_ROW_L:    acc_r <= mul;
        DP_ROW_K:    acc_r <= acc_r + mul;
        DP_ROW_END:  nx_r[cmd.row] <= sat32(shifted);
        DP_COMMIT: begin
          for (int i = 0; i < NumStates; i++) x_r[i] <= nx_r[i];
          acc_r <= '0;
        end
        DP_DRV_K:    acc_r <= acc_r + mul;
        DP_DRV_END:  drive_r <= sat32(shifted);
        DP_ZERO_DRV: drive_r <= '0;
        DP_MAG:      mag_r <= 44'(dmag) * 44'(drive_scale);
        DP_COMMUTE: begin
          if (hall_r != 3'd0 && hall_r != 3'd7) begin
            // high side of a phase at even slots, low side at odd slots
            for (int i = 0; i < 6; i++)
              duty_r[i] <= (3'(i) == {hi, 1'b0} || 3'(i) == {lo, 1'b1}) ? torque : 12'd0;
            ind_r <= hall_r;
          end
        end
        DP_REPORT: begin
          out_duty_a_high      <= duty_r[0];
          out_duty_a_low       <= duty_r[1];
          out_duty_b_high      <= duty_r[2];
          out_duty_b_low       <= duty_r[3];
          out_duty_c_high      <= duty_r[4];
          out_duty_c_low       <= duty_r[5];
          out_hall_indicator   <= ind_r;
          out_reference_report <= ref_r;
          out_count_report     <= cmd.use_cnt ? cnt_r : 16'sd0;
          if ((mag_r >> FRAC_BITS) > 44'd32767)
            out_drive_report <= drive_r[31] ? -16'sd32768 : 16'sd32767;
          else if (drive_r[31])
            out_drive_report <= -16'(mag_r >> FRAC_BITS);
          else
            out_drive_report <= 16'(mag_r >> FRAC_BITS);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lqg_speed_regulator_six_step.sv =====
// LQG speed regulator with six-step commutation. Each transaction on the in_
// channel yields exactly one result on the out_ channel. For a control tick
// (operation 0) the estimator update and drive are worked on one shared
// 32x32 multiplier, four multiply-accumulates per estimator row plus three
// for the drive, then a scale multiply and the commutation step. A
// hall-change transaction runs only the scale multiply and the commutation
// step; a control tick once the run limit is reached zeroes the drive and
// runs the scale multiply. The next transaction can be accepted in the cycle
// that the result is presented; a result held by out_stall also holds the
// next result and the input. The block handles one transaction at a time;
// configuration goes through the cfg_ APB port at byte addresses 0, 4, 8, 12.
`default_nettype none
module lqg_speed_regulator_six_step
  import lqg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [3:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [15:0] in_count_delta,
  input  wire logic               in_excite_bit,
  input  wire logic [2:0]         in_hall_bits,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [11:0]             out_duty_a_high,
  output logic [11:0]             out_duty_a_low,
  output logic [11:0]             out_duty_b_high,
  output logic [11:0]             out_duty_b_low,
  output logic [11:0]             out_duty_c_high,
  output logic [11:0]             out_duty_c_low,
  output logic [2:0]              out_hall_indicator,
  output logic signed [15:0]      out_drive_report,
  output logic [15:0]             out_reference_report,
  output logic signed [15:0]      out_count_report
);

  logic [15:0] excite_r;
  logic [11:0] scale_r;
  logic [31:0] counts_r;
  logic [21:0] limit_r;
  reg_idx_t    idx;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign cfg_pready = 1'b1;
  assign idx = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    case (idx)
      REG_EXCITE: cfg_prdata = {16'd0, excite_r};
      REG_SCALE:  cfg_prdata = {20'd0, scale_r};
      REG_COUNTS: cfg_prdata = counts_r;
      REG_LIMIT:  cfg_prdata = {10'd0, limit_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excite_r <= 16'd250;
      scale_r  <= 12'd1750;
      counts_r <= 32'd2412423;
      limit_r  <= 22'd3342285;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (idx)
        REG_EXCITE: excite_r <= cfg_pwdata[15:0];
        REG_SCALE:  scale_r  <= cfg_pwdata[11:0];
        REG_COUNTS: counts_r <= cfg_pwdata;
        REG_LIMIT:  limit_r  <= cfg_pwdata[21:0];
        default: ;
      endcase
    end
  end

  lqg_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_operation,
    .out_valid, .out_stall, .stat, .cmd
  );

  lqg_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_take(in_valid && !in_stall),
    .in_count_delta, .in_excite_bit, .in_hall_bits,
    .excite_speed(excite_r), .drive_scale(scale_r),
    .counts_scale(counts_r), .run_limit(limit_r),
    .out_duty_a_high, .out_duty_a_low, .out_duty_b_high, .out_duty_b_low,
    .out_duty_c_high, .out_duty_c_low, .out_hall_indicator,
    .out_drive_report, .out_reference_report, .out_count_report
  );

endmodule
`default_nettype wire
